FILE: hdl/rcp_pkg.sv
package rcp_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int FRAC_BITS  = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int COORD_W    = 24;
	localparam int EXT_W      = COORD_W + 2;
	localparam int DIM_W      = 10;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_DRAW  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [7:0] KIND_OUTLINE = 8'h72;
	localparam logic [7:0] KIND_FILLED  = 8'h52;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BG     = 2'd2;

	localparam logic [EXT_W-1:0] ONE_FX = EXT_W'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_PAINT,
		OP_READ,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic                     filled;
		logic signed [EXT_W-1:0]  x0;
		logic signed [EXT_W-1:0]  y0;
		logic signed [EXT_W-1:0]  x1;
		logic signed [EXT_W-1:0]  y1;
		logic [7:0]               chr;
		logic [COL_W-1:0]         col;
		logic [ROW_W-1:0]         row;
		logic                     in_area;
		logic                     flag;
	} cmd_t;

endpackage

FILE: hdl/rcp_front.sv
module rcp_front
	import rcp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              action,
	input  logic [7:0]              shape_kind,
	input  logic signed [COORD_W-1:0] rect_x,
	input  logic signed [COORD_W-1:0] rect_y,
	input  logic signed [COORD_W-1:0] rect_w,
	input  logic signed [COORD_W-1:0] rect_h,
	input  logic [7:0]              paint_char,
	input  logic [8:0]              read_col,
	input  logic [8:0]              read_row,
	input  logic [DIM_W-1:0]        wd,
	input  logic [DIM_W-1:0]        ht,
	output logic                    q_valid,
	input  logic                    q_ready,
	output cmd_t                    q_cmd
);

	logic flag_q;
	cmd_t c;
	logic bad;
	logic [DIM_W-1:0] col_e, row_e;

	assign in_ready = !q_valid || q_ready;
	assign bad = (rect_w <= 0) || (rect_h <= 0) ||
		((shape_kind != KIND_OUTLINE) && (shape_kind != KIND_FILLED));
	assign col_e = DIM_W'(read_col);
	assign row_e = DIM_W'(read_row);

	always_comb begin
		c = '0;
		c.x0 = EXT_W'(rect_x);
		c.y0 = EXT_W'(rect_y);
		c.x1 = EXT_W'(rect_x) + EXT_W'(rect_w);
		c.y1 = EXT_W'(rect_y) + EXT_W'(rect_h);
		c.filled = shape_kind == KIND_FILLED;
		c.chr = paint_char;
		c.col = COL_W'(read_col);
		c.row = ROW_W'(read_row);
		c.in_area = (col_e < wd) && (row_e < ht);
		c.flag = flag_q;
		case (action)
			ACT_CLEAR: begin
				c.op = OP_CLEAR;
				c.flag = 1'b0;
			end
			ACT_DRAW: begin
				if (flag_q || bad) begin
					c.op = OP_NONE;
					c.flag = 1'b1;
				end else begin
					c.op = OP_PAINT;
				end
			end
			ACT_READ: c.op = OP_READ;
			default: c.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid <= 1'b0;
			flag_q  <= 1'b0;
		end else if (in_valid && in_ready) begin
			q_valid <= 1'b1;
			flag_q  <= c.flag;
		end else if (q_ready) begin
			q_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			q_cmd <= c;
	end

endmodule

FILE: hdl/rcp_back.sv
module rcp_back
	import rcp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  cmd_t             q_cmd,
	input  logic [DIM_W-1:0] wd,
	input  logic [DIM_W-1:0] ht,
	input  logic [7:0]       bg,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       pixel_char,
	output logic             corrupted
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	logic [1:0] state_q;
	cmd_t cmd_q;
	logic [COL_W-1:0] c_q;
	logic [ROW_W-1:0] r_q;
	logic [7:0] mem [MAX_WIDTH*MAX_HEIGHT];
	logic [7:0] rd_q;
	logic signed [EXT_W-1:0] px, py;
	logic in_rect, border, we, last_c, last_r, out_busy;
	logic [7:0] wdata;

	assign px = EXT_W'({c_q, {FRAC_BITS{1'b0}}});
	assign py = EXT_W'({r_q, {FRAC_BITS{1'b0}}});
	assign in_rect = (px >= cmd_q.x0) && (px <= cmd_q.x1) &&
		(py >= cmd_q.y0) && (py <= cmd_q.y1);
	assign border = (px - cmd_q.x0 < ONE_FX) || (cmd_q.x1 - px < ONE_FX) ||
		(py - cmd_q.y0 < ONE_FX) || (cmd_q.y1 - py < ONE_FX);
	assign we = (state_q == ST_SWEEP) && ((cmd_q.op == OP_CLEAR) ||
		(in_rect && (border || cmd_q.filled)));
	assign wdata = (cmd_q.op == OP_CLEAR) ? bg : cmd_q.chr;
	assign last_c = DIM_W'(c_q) + 1'b1 >= wd;
	assign last_r = DIM_W'(r_q) + 1'b1 >= ht;
	assign out_busy = out_valid && !out_ready;
	assign q_ready = (state_q == ST_IDLE) && !out_busy;

	always_ff @(posedge clk) begin
		if (we)
			mem[{r_q, c_q}] <= wdata;
		rd_q <= mem[{cmd_q.row, cmd_q.col}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			c_q <= '0;
			r_q <= '0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_ready) begin
						c_q <= '0;
						r_q <= '0;
						case (q_cmd.op)
							OP_CLEAR, OP_PAINT: state_q <= ST_SWEEP;
							OP_READ: state_q <= ST_READ;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_SWEEP: begin
					if (last_c) begin
						c_q <= '0;
						if (last_r)
							state_q <= ST_OUT;
						else
							r_q <= r_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_READ: state_q <= ST_OUT;
				ST_OUT: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready)
			cmd_q <= q_cmd;
		if (state_q == ST_OUT) begin
			pixel_char <= (cmd_q.op == OP_READ && cmd_q.in_area) ? rd_q : 8'd0;
			corrupted  <= cmd_q.flag;
		end
	end

endmodule

FILE: hdl/rectangle_canvas_painter_core.sv
// channel  dir  handshake                    payload
// in       in   in_valid / in_ready          action .. read_row
// out      out  out_valid / out_ready        pixel_char, corrupted
// cfg      in   cfg_we                       cfg_index, cfg_data
// clear and draw sweep the used area, one pixel a cycle, then pass ST_OUT to out_valid
// a read passes ST_READ and ST_OUT on its way to out_valid, an ignored beat only ST_OUT
// reset clears control and flag; the canvas is undefined until a clear
// the front takes the next beat while the back sweeps; out stall holds the back
module rectangle_canvas_painter_core
	import rcp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [DIM_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                action,
	input  logic [7:0]                shape_kind,
	input  logic signed [COORD_W-1:0] rect_x,
	input  logic signed [COORD_W-1:0] rect_y,
	input  logic signed [COORD_W-1:0] rect_w,
	input  logic signed [COORD_W-1:0] rect_h,
	input  logic [7:0]                paint_char,
	input  logic [8:0]                read_col,
	input  logic [8:0]                read_row,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                pixel_char,
	output logic                      corrupted
);

	logic [DIM_W-1:0] width_q, height_q, wd, ht;
	logic [7:0] bg_q;
	logic q_valid, q_ready;
	cmd_t q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			bg_q     <= 8'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_BG:     bg_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign wd = (width_q == '0) ? DIM_W'(1) :
		(width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
	assign ht = (height_q == '0) ? DIM_W'(1) :
		(height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;

	rcp_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .action, .shape_kind,
		.rect_x, .rect_y, .rect_w, .rect_h, .paint_char, .read_col, .read_row,
		.wd, .ht, .q_valid, .q_ready, .q_cmd
	);

	rcp_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd, .wd, .ht, .bg(bg_q),
		.out_valid, .out_ready, .pixel_char, .corrupted
	);

`ifndef SYNTHESIS
	a_clear_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && action == ACT_CLEAR) |=> !u_front.flag_q)
		else $error("flag not cleared");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pixel_char)))
		else $error("result dropped");
	a_q_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && !q_ready) |=> q_valid)
		else $error("queue beat lost");
`endif

endmodule
